// ===== hdl/zero_copy_request_estimator_assert.svh =====
// Assertion macros used by the estimator's top-level RTL file.
`ifndef ZERO_COPY_REQUEST_ESTIMATOR_ASSERT_SVH
`define ZERO_COPY_REQUEST_ESTIMATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZCRE_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZCRE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/zcre_pkg.sv =====
`default_nettype none

package zcre_pkg;

   localparam int ENTRY_BYTES = 4;
   localparam int OFFSET_BITS = 40;

   localparam int EDGE_W  = OFFSET_BITS;
   localparam int NUM_W   = 32;
   localparam int PART_W  = 20;
   localparam int REQ_W   = 42;
   localparam int KIND_W  = 2;
   localparam int CFG_W   = 13;
   localparam int RPP_W   = 11;
   localparam int IDX_W   = 2;
   localparam int BYTES_W = OFFSET_BITS + $clog2(ENTRY_BYTES);
   localparam int DIV_W   = (BYTES_W > REQ_W) ? BYTES_W : REQ_W;
   localparam int DIVR_W  = CFG_W;
   localparam int CNT_W   = $clog2(DIV_W + 1);

   localparam logic [CFG_W-1:0] REQ_SIZE_RESET = CFG_W'(128);
   localparam logic [CFG_W-1:0] ALIGN_RESET    = CFG_W'(64);
   localparam logic [RPP_W-1:0] RPP_RESET      = RPP_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_VERTEX,
      KIND_PART,
      KIND_TOTAL
   } kind_type;

   typedef enum logic [IDX_W-1:0] {
      REG_REQ_SIZE,
      REG_ALIGN,
      REG_RPP
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_VREC,
      ST_PREC,
      ST_PDIV,
      ST_TREC
   } st_type;

   typedef struct packed {
      kind_type           record_kind;
      logic [NUM_W-1:0]   item_number;
      logic [EDGE_W-1:0]  edges_sum;
      logic [REQ_W-1:0]   requests_sum;
      logic [NUM_W-1:0]   misaligned_sum;
      logic [NUM_W-1:0]   vertices_active_sum;
      logic [PART_W-1:0]  partitions_active_sum;
      logic [REQ_W-1:0]   packet_total;
      logic               last_record;
   } rsp_rec_type;

   typedef struct packed {
      logic               done;
      logic               rem_nz;
      logic [DIV_W-1:0]   ceil_quo;
   } div_res_type;

   typedef struct packed {
      logic               vtx_add;
      logic               vtx_skip;
      logic               part_close;
      logic               graph_clear;
      logic [EDGE_W-1:0]  deg;
      logic [REQ_W-1:0]   reqs;
      logic               mis;
   } acc_ctrl_type;

   typedef struct packed {
      logic [NUM_W-1:0]   vertex_number;
      logic [PART_W-1:0]  partition_number;
      logic [NUM_W-1:0]   part_vertices;
      logic [EDGE_W-1:0]  part_edges;
      logic [REQ_W-1:0]   part_requests;
      logic [NUM_W-1:0]   part_misaligned;
      logic [NUM_W-1:0]   total_vertices;
      logic [EDGE_W-1:0]  total_edges;
      logic [REQ_W-1:0]   total_requests;
      logic [NUM_W-1:0]   total_misaligned;
      logic [PART_W-1:0]  total_partitions;
   } acc_sums_type;

endpackage

`default_nettype wire

// ===== hdl/zcre_ifs.sv =====
`default_nettype none

interface zcre_req_if;
   import zcre_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OFFSET_BITS-1:0] row_start;
   logic [OFFSET_BITS-1:0] row_stop;
   logic                   active;
   logic                   closes_partition;
   logic                   closes_graph;

   modport source (output valid, row_start, row_stop, active, closes_partition,
                   closes_graph, input ready);
   modport sink (input valid, row_start, row_stop, active, closes_partition,
                 closes_graph, output ready);
endinterface

interface zcre_rsp_if;
   import zcre_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] record_kind;
   logic [NUM_W-1:0]  item_number;
   logic [EDGE_W-1:0] edges_sum;
   logic [REQ_W-1:0]  requests_sum;
   logic [NUM_W-1:0]  misaligned_sum;
   logic [NUM_W-1:0]  vertices_active_sum;
   logic [PART_W-1:0] partitions_active_sum;
   logic [REQ_W-1:0]  packet_total;
   logic              last_record;

   modport source (output valid, record_kind, item_number, edges_sum, requests_sum,
                   misaligned_sum, vertices_active_sum, partitions_active_sum,
                   packet_total, last_record, input ready);
   modport sink (input valid, record_kind, item_number, edges_sum, requests_sum,
                 misaligned_sum, vertices_active_sum, partitions_active_sum,
                 packet_total, last_record, output ready);
endinterface

interface zcre_csr_if;
   import zcre_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [CFG_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/zcre_div.sv =====
`default_nettype none

module zcre_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [zcre_pkg::DIV_W-1:0]  dividend,
   input  logic [zcre_pkg::DIVR_W-1:0] divisor,
   output zcre_pkg::div_res_type       res
);
   import zcre_pkg::*;

   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIVR_W:0]   trial;
   logic [DIVR_W:0]   trial_sub;
   logic              fits;
   logic              rem_nz;

   // One quotient bit a cycle: the partial remainder never exceeds the divisor width.
   always_comb begin
      trial     = {rem_ff, dvd_ff[DIV_W-1]};
      fits      = (trial >= {1'b0, dsr_ff});
      trial_sub = trial - {1'b0, dsr_ff};
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         dvd_in  = {dvd_ff[DIV_W-2:0], fits};
         rem_in  = fits ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rem_nz       = (rem_ff != '0);
   assign res.done     = done_ff;
   assign res.rem_nz   = rem_nz;
   assign res.ceil_quo = dvd_ff + DIV_W'(rem_nz);

endmodule

`default_nettype wire

// ===== hdl/zcre_acc.sv =====
`default_nettype none

module zcre_acc (
   input  logic                   clock,
   input  logic                   reset,
   input  zcre_pkg::acc_ctrl_type ctrl,
   output zcre_pkg::acc_sums_type sums
);
   import zcre_pkg::*;

   acc_sums_type sums_ff, sums_in;

   function automatic logic [NUM_W-1:0] sat_num(input logic [NUM_W-1:0] a,
                                                input logic [NUM_W-1:0] b);
      logic [NUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[NUM_W] ? {NUM_W{1'b1}} : s[NUM_W-1:0];
   endfunction

   function automatic logic [EDGE_W-1:0] sat_edge(input logic [EDGE_W-1:0] a,
                                                  input logic [EDGE_W-1:0] b);
      logic [EDGE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[EDGE_W] ? {EDGE_W{1'b1}} : s[EDGE_W-1:0];
   endfunction

   function automatic logic [REQ_W-1:0] sat_req(input logic [REQ_W-1:0] a,
                                                input logic [REQ_W-1:0] b);
      logic [REQ_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[REQ_W] ? {REQ_W{1'b1}} : s[REQ_W-1:0];
   endfunction

   function automatic logic [PART_W-1:0] sat_part_inc(input logic [PART_W-1:0] a);
      logic [PART_W:0] s;
      s = {1'b0, a} + (PART_W+1)'(1);
      return s[PART_W] ? {PART_W{1'b1}} : s[PART_W-1:0];
   endfunction

   always_comb begin
      sums_in = sums_ff;
      if (ctrl.vtx_add) begin
         sums_in.part_vertices    = sat_num(sums_ff.part_vertices, NUM_W'(1));
         sums_in.part_edges       = sat_edge(sums_ff.part_edges, ctrl.deg);
         sums_in.part_requests    = sat_req(sums_ff.part_requests, ctrl.reqs);
         sums_in.part_misaligned  = sat_num(sums_ff.part_misaligned, NUM_W'(ctrl.mis));
         sums_in.total_vertices   = sat_num(sums_ff.total_vertices, NUM_W'(1));
         sums_in.total_edges      = sat_edge(sums_ff.total_edges, ctrl.deg);
         sums_in.total_requests   = sat_req(sums_ff.total_requests, ctrl.reqs);
         sums_in.total_misaligned = sat_num(sums_ff.total_misaligned, NUM_W'(ctrl.mis));
      end
      if (ctrl.vtx_add || ctrl.vtx_skip) begin
         sums_in.vertex_number = sums_ff.vertex_number + NUM_W'(1);
      end
      if (ctrl.part_close) begin
         if (sums_ff.part_vertices != '0) begin
            sums_in.total_partitions = sat_part_inc(sums_ff.total_partitions);
         end
         sums_in.partition_number = sums_ff.partition_number + PART_W'(1);
         sums_in.part_vertices    = '0;
         sums_in.part_edges       = '0;
         sums_in.part_requests    = '0;
         sums_in.part_misaligned  = '0;
      end
      if (ctrl.graph_clear) begin
         sums_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else begin
         sums_ff <= sums_in;
      end
   end

   assign sums = sums_ff;

endmodule

`default_nettype wire

// ===== hdl/zero_copy_request_estimator.sv =====
// Channel   Direction  Word
// req_chan  in         one vertex: row_start, row_stop and its three flags
// rsp_chan  out        one record: vertex, partition or whole-graph totals
// csr_chan  in         register index and write data, always ready
//
// An active vertex passes ST_DIV, where the bit-serial dividers work, and ST_VREC
// before its record sits in the output register; an inactive vertex that closes
// nothing yields no record. A partition close adds ST_PREC, a graph close a further
// ST_PDIV and ST_TREC for the packet division on the same divider.
// Reset is synchronous and clears all sums and counters; the registers return to
// 128, 64 and 1. A stalled result channel holds the pending word; the next vertex
// is accepted once the last record of the previous one is in the output register.
`default_nettype none

`include "zero_copy_request_estimator_assert.svh"

module zero_copy_request_estimator (
   input logic         clock,
   input logic         reset,
   zcre_req_if.sink    req_chan,
   zcre_rsp_if.source  rsp_chan,
   zcre_csr_if.sink    csr_chan
);
   import zcre_pkg::*;

   st_type            state_ff, state_in;
   logic [CFG_W-1:0]  req_size_ff, req_size_in;
   logic [CFG_W-1:0]  align_ff, align_in;
   logic [RPP_W-1:0]  rpp_ff, rpp_in;
   logic              part_end_ff, part_end_in;
   logic              graph_end_ff, graph_end_in;
   logic [EDGE_W-1:0] deg_ff, deg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_rec_type       out_ff, out_in;

   logic              accept;
   logic              out_free;
   logic              load;
   rsp_rec_type       rec;
   logic [EDGE_W-1:0] diff;
   logic [EDGE_W-1:0] degree;
   logic [DIV_W-1:0]  bytes;
   logic [DIV_W-1:0]  offset;
   logic [CFG_W-1:0]  req_size_eff;
   logic [CFG_W-1:0]  align_eff;
   logic [CFG_W-1:0]  rpp_eff;
   logic              qdiv_start;
   logic [DIV_W-1:0]  qdiv_dividend;
   logic [CFG_W-1:0]  qdiv_divisor;
   logic              mdiv_start;
   logic [REQ_W-1:0]  quo_sat;
   logic              mis_bit;
   div_res_type       qres;
   div_res_type       mres;
   acc_ctrl_type      ctrl;
   acc_sums_type      sums;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign diff   = req_chan.row_stop - req_chan.row_start;
   assign degree = (req_chan.row_stop >= req_chan.row_start) ? diff : '0;
   assign bytes  = DIV_W'(degree) * DIV_W'(ENTRY_BYTES);
   assign offset = DIV_W'(req_chan.row_start) * DIV_W'(ENTRY_BYTES);

   // A register written as zero behaves as one.
   assign req_size_eff = (req_size_ff == '0) ? CFG_W'(1) : req_size_ff;
   assign align_eff    = (align_ff == '0) ? CFG_W'(1) : align_ff;
   assign rpp_eff      = (rpp_ff == '0) ? CFG_W'(1) : CFG_W'(rpp_ff);

   assign quo_sat = ((qres.ceil_quo >> REQ_W) != '0) ? {REQ_W{1'b1}}
                                                       : REQ_W'(qres.ceil_quo);
   assign mis_bit = (deg_ff != '0) && mres.rem_nz;

   always_comb begin
      req_size_in = req_size_ff;
      align_in    = align_ff;
      rpp_in      = rpp_ff;
      if (csr_chan.valid) begin
         case (reg_idx_type'(csr_chan.index))
            REG_REQ_SIZE: req_size_in = csr_chan.data;
            REG_ALIGN:    align_in    = csr_chan.data;
            REG_RPP:      rpp_in      = csr_chan.data[RPP_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      part_end_in   = part_end_ff;
      graph_end_in  = graph_end_ff;
      deg_in        = deg_ff;
      load          = 1'b0;
      rec           = '0;
      qdiv_start    = 1'b0;
      qdiv_dividend = bytes;
      qdiv_divisor  = req_size_eff;
      mdiv_start    = 1'b0;
      ctrl          = '0;
      ctrl.deg      = deg_ff;
      ctrl.reqs     = quo_sat;
      ctrl.mis      = mis_bit;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               part_end_in  = req_chan.closes_partition || req_chan.closes_graph;
               graph_end_in = req_chan.closes_graph;
               deg_in       = degree;
               if (req_chan.active) begin
                  qdiv_start = 1'b1;
                  mdiv_start = 1'b1;
                  state_in   = ST_DIV;
               end else begin
                  ctrl.vtx_skip = 1'b1;
                  state_in = (req_chan.closes_partition || req_chan.closes_graph)
                             ? ST_PREC : ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (qres.done) begin
               state_in = ST_VREC;
            end
         end
         ST_VREC: begin
            rec.record_kind         = KIND_VERTEX;
            rec.item_number         = sums.vertex_number;
            rec.edges_sum           = deg_ff;
            rec.requests_sum        = quo_sat;
            rec.misaligned_sum      = NUM_W'(mis_bit);
            rec.vertices_active_sum = NUM_W'(1);
            rec.last_record         = !part_end_ff;
            if (out_free) begin
               load         = 1'b1;
               ctrl.vtx_add = 1'b1;
               state_in     = part_end_ff ? ST_PREC : ST_IDLE;
            end
         end
         ST_PREC: begin
            rec.record_kind         = KIND_PART;
            rec.item_number         = NUM_W'(sums.partition_number);
            rec.edges_sum           = sums.part_edges;
            rec.requests_sum        = sums.part_requests;
            rec.misaligned_sum      = sums.part_misaligned;
            rec.vertices_active_sum = sums.part_vertices;
            rec.last_record         = !graph_end_ff;
            if (out_free) begin
               load            = 1'b1;
               ctrl.part_close = 1'b1;
               if (graph_end_ff) begin
                  qdiv_start    = 1'b1;
                  qdiv_dividend = DIV_W'(sums.total_requests);
                  qdiv_divisor  = rpp_eff;
                  state_in      = ST_PDIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PDIV: begin
            if (qres.done) begin
               state_in = ST_TREC;
            end
         end
         ST_TREC: begin
            rec.record_kind           = KIND_TOTAL;
            rec.edges_sum             = sums.total_edges;
            rec.requests_sum          = sums.total_requests;
            rec.misaligned_sum        = sums.total_misaligned;
            rec.vertices_active_sum   = sums.total_vertices;
            rec.partitions_active_sum = sums.total_partitions;
            rec.packet_total          = quo_sat;
            rec.last_record           = 1'b1;
            if (out_free) begin
               load             = 1'b1;
               ctrl.graph_clear = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (load) begin
         out_in       = rec;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_size_ff  <= REQ_SIZE_RESET;
         align_ff     <= ALIGN_RESET;
         rpp_ff       <= RPP_RESET;
         part_end_ff  <= 1'b0;
         graph_end_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_size_ff  <= req_size_in;
         align_ff     <= align_in;
         rpp_ff       <= rpp_in;
         part_end_ff  <= part_end_in;
         graph_end_ff <= graph_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      deg_ff <= deg_in;
      out_ff <= out_in;
   end

   zcre_div u_qdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (qdiv_start),
      .dividend (qdiv_dividend),
      .divisor  (qdiv_divisor),
      .res      (qres)
   );

   zcre_div u_mdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (mdiv_start),
      .dividend (offset),
      .divisor  (align_eff),
      .res      (mres)
   );

   zcre_acc u_acc (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .sums  (sums)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid                 = rsp_valid_ff;
   assign rsp_chan.record_kind           = out_ff.record_kind;
   assign rsp_chan.item_number           = out_ff.item_number;
   assign rsp_chan.edges_sum             = out_ff.edges_sum;
   assign rsp_chan.requests_sum          = out_ff.requests_sum;
   assign rsp_chan.misaligned_sum        = out_ff.misaligned_sum;
   assign rsp_chan.vertices_active_sum   = out_ff.vertices_active_sum;
   assign rsp_chan.partitions_active_sum = out_ff.partitions_active_sum;
   assign rsp_chan.packet_total          = out_ff.packet_total;
   assign rsp_chan.last_record           = out_ff.last_record;

   `ZCRE_ASSERT_SAME(dividers_in_step, clock, reset, (state_ff == ST_DIV) && qres.done, mres.done, "alignment divider out of step with request divider")
   `ZCRE_ASSERT_NEXT(totals_cleared, clock, reset, load && (state_ff == ST_TREC), (sums.total_requests == '0) && (sums.vertex_number == '0), "sums not cleared after totals word")
   `ZCRE_ASSERT_SAME(part_within_total, clock, reset, 1'b1, (sums.part_vertices <= sums.total_vertices) && (sums.part_requests <= sums.total_requests), "partition sum exceeds graph sum")

endmodule

`default_nettype wire

// ===== dv/zcre_estimate_checker.sv =====
`timescale 1ns / 1ps

module zcre_estimate_checker (
   input  logic  clock,
   input  logic  reset,
   zcre_req_if   req,
   zcre_rsp_if   rsp,
   zcre_csr_if   csr,
   output int    mismatch_count,
   output int    records_pending
);
   import zcre_pkg::*;

   localparam logic [63:0] NUM_MAX  = (64'd1 << NUM_W) - 64'd1;
   localparam logic [63:0] PART_MAX = (64'd1 << PART_W) - 64'd1;
   localparam logic [63:0] EDGE_MAX = (64'd1 << EDGE_W) - 64'd1;
   localparam logic [63:0] REQ_MAX  = (64'd1 << REQ_W) - 64'd1;

   logic [63:0] request_bytes, align_bytes, reqs_per_packet;
   logic [63:0] vertex_no, partition_no;
   logic [63:0] part_vertices, part_edges, part_requests, part_misaligned;
   logic [63:0] total_vertices, total_edges, total_requests, total_misaligned;
   logic [63:0] total_partitions;
   rsp_rec_type pending_records[$];
   int          fault_tally;

   function automatic logic [63:0] quot_up(logic [63:0] num, logic [63:0] den);
      logic [63:0] d;
      d = (den == 64'd0) ? 64'd1 : den;
      return num / d + (((num % d) != 64'd0) ? 64'd1 : 64'd0);
   endfunction

   function automatic logic [63:0] clamp(logic [63:0] v, logic [63:0] lim);
      return (v > lim) ? lim : v;
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] lim);
      if (a >= lim || b >= lim - a) return lim;
      return a + b;
   endfunction

   function automatic rsp_rec_type make_record(kind_type kind, logic [63:0] num,
                                               logic [63:0] edges, logic [63:0] reqs,
                                               logic [63:0] mis, logic [63:0] verts,
                                               logic [63:0] parts, logic [63:0] packets,
                                               logic last);
      rsp_rec_type rec;
      rec.record_kind           = kind;
      rec.item_number           = num[NUM_W-1:0];
      rec.edges_sum             = edges[EDGE_W-1:0];
      rec.requests_sum          = reqs[REQ_W-1:0];
      rec.misaligned_sum        = mis[NUM_W-1:0];
      rec.vertices_active_sum   = verts[NUM_W-1:0];
      rec.partitions_active_sum = parts[PART_W-1:0];
      rec.packet_total          = packets[REQ_W-1:0];
      rec.last_record           = last;
      return rec;
   endfunction

   function automatic string record_text(rsp_rec_type r);
      return $sformatf("kind %0d item %0d edges %h reqs %h mis %0d verts %0d parts %0d pkts %h last %b",
                       r.record_kind, r.item_number, r.edges_sum, r.requests_sum,
                       r.misaligned_sum, r.vertices_active_sum, r.partitions_active_sum,
                       r.packet_total, r.last_record);
   endfunction

   task automatic clear_sums();
      vertex_no        = '0;
      partition_no     = '0;
      part_vertices    = '0;
      part_edges       = '0;
      part_requests    = '0;
      part_misaligned  = '0;
      total_vertices   = '0;
      total_edges      = '0;
      total_requests   = '0;
      total_misaligned = '0;
      total_partitions = '0;
   endtask

   task automatic account_vertex(logic [63:0] first, logic [63:0] next, logic act,
                                 logic part_close, logic graph_close);
      logic [63:0] degree, reqs, mis, align_d, packets;
      logic        part_end;
      part_end = part_close | graph_close;
      if (act) begin
         degree  = (next >= first) ? next - first : 64'd0;
         reqs    = clamp(quot_up(degree * ENTRY_BYTES, request_bytes), REQ_MAX);
         align_d = (align_bytes == 64'd0) ? 64'd1 : align_bytes;
         mis     = (degree != 64'd0 && ((first * ENTRY_BYTES) % align_d) != 64'd0)
                   ? 64'd1 : 64'd0;
         degree  = clamp(degree, EDGE_MAX);
         part_vertices    = add_sat(part_vertices, 64'd1, NUM_MAX);
         part_edges       = add_sat(part_edges, degree, EDGE_MAX);
         part_requests    = add_sat(part_requests, reqs, REQ_MAX);
         part_misaligned  = add_sat(part_misaligned, mis, NUM_MAX);
         total_vertices   = add_sat(total_vertices, 64'd1, NUM_MAX);
         total_edges      = add_sat(total_edges, degree, EDGE_MAX);
         total_requests   = add_sat(total_requests, reqs, REQ_MAX);
         total_misaligned = add_sat(total_misaligned, mis, NUM_MAX);
         pending_records = {pending_records,
                            make_record(KIND_VERTEX, vertex_no, degree, reqs, mis,
                                        64'd1, 64'd0, 64'd0, !part_end)};
      end
      vertex_no = (vertex_no + 64'd1) & NUM_MAX;
      if (part_end) begin
         if (part_vertices != 64'd0)
            total_partitions = add_sat(total_partitions, 64'd1, PART_MAX);
         pending_records = {pending_records,
                            make_record(KIND_PART, partition_no, part_edges,
                                        part_requests, part_misaligned,
                                        part_vertices, 64'd0, 64'd0, !graph_close)};
         partition_no    = (partition_no + 64'd1) & PART_MAX;
         part_vertices   = '0;
         part_edges      = '0;
         part_requests   = '0;
         part_misaligned = '0;
      end
      if (graph_close) begin
         packets = clamp(quot_up(total_requests, reqs_per_packet), REQ_MAX);
         pending_records = {pending_records,
                            make_record(KIND_TOTAL, 64'd0, total_edges,
                                        total_requests, total_misaligned,
                                        total_vertices, total_partitions,
                                        packets, 1'b1)};
         clear_sums();
      end
   endtask

   always @(posedge clock) begin
      rsp_rec_type got, want;
      if (reset) begin
         request_bytes   = 64'(REQ_SIZE_RESET);
         align_bytes     = 64'(ALIGN_RESET);
         reqs_per_packet = 64'(RPP_RESET);
         clear_sums();
         pending_records.delete();
         fault_tally = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.record_kind           = kind_type'(rsp.record_kind);
            got.item_number           = rsp.item_number;
            got.edges_sum             = rsp.edges_sum;
            got.requests_sum          = rsp.requests_sum;
            got.misaligned_sum        = rsp.misaligned_sum;
            got.vertices_active_sum   = rsp.vertices_active_sum;
            got.partitions_active_sum = rsp.partitions_active_sum;
            got.packet_total          = rsp.packet_total;
            got.last_record           = rsp.last_record;
            if (pending_records.size() == 0) begin
               fault_tally++;
               if (fault_tally <= 10)
                  $display("Unexpected word: %s", record_text(got));
            end else begin
               want = pending_records.pop_front();
               if (got !== want) begin
                  fault_tally++;
                  if (fault_tally <= 10) begin
                     $display("Wrong word, expected: %s", record_text(want));
                     $display("              actual: %s", record_text(got));
                  end
               end
            end
         end
         if (csr.valid && csr.ready) begin
            case (reg_idx_type'(csr.index))
               REG_REQ_SIZE: request_bytes   = 64'(csr.data);
               REG_ALIGN:    align_bytes     = 64'(csr.data);
               REG_RPP:      reqs_per_packet = 64'(csr.data[RPP_W-1:0]);
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            account_vertex(64'(req.row_start), 64'(req.row_stop), req.active,
                           req.closes_partition, req.closes_graph);
      end
      mismatch_count  <= fault_tally;
      records_pending <= pending_records.size();
   end

endmodule

// ===== dv/zero_copy_request_estimator_tb.sv =====
`timescale 1ns / 1ps

module zero_copy_request_estimator_tb;
   import zcre_pkg::*;

   localparam int                     IDLE_LIMIT    = 4000;
   localparam int                     SETTLE_CYCLES = 2 * (DIV_W + 2) + 8;
   localparam logic [IDX_W-1:0]       REG_SPARE     = 2'd3;
   localparam logic [OFFSET_BITS-1:0] OFS_MAX       = '1;

   logic                   clock;
   logic                   reset;
   logic                   sink_ready = 1'b0;
   logic [7:0]             stall_tick = '0;
   int                     mismatch_count;
   int                     records_pending;
   int                     idle_cycles = 0;
   int                     burst_left = 0;
   logic [OFFSET_BITS-1:0] row_cursor;

   zcre_req_if req_chan ();
   zcre_rsp_if rsp_chan ();
   zcre_csr_if csr_chan ();

   zero_copy_request_estimator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   zcre_estimate_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req             (req_chan),
      .rsp             (rsp_chan),
      .csr             (csr_chan),
      .mismatch_count  (mismatch_count),
      .records_pending (records_pending)
   );

   assign rsp_chan.ready = sink_ready;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // The receiver cycles through steady acceptance, light stalls, long stalls and coin tosses.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      case (stall_tick[7:6])
         2'd0: sink_ready <= 1'b1;
         2'd1: sink_ready <= ($urandom_range(0, 3) != 0);
         2'd2: sink_ready <= (stall_tick[3:0] > 4'd11);
         default: sink_ready <= 1'($urandom_range(0, 1));
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_vertex(logic [OFFSET_BITS-1:0] first, logic [OFFSET_BITS-1:0] next,
                              logic act, logic part_close, logic graph_close);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 9);
         if (gap != 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_chan.row_start        = first;
      req_chan.row_stop         = next;
      req_chan.active           = act;
      req_chan.closes_partition = part_close;
      req_chan.closes_graph     = graph_close;
      req_chan.valid            = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid = 1'b0;
      while (records_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
      csr_chan.index = index;
      csr_chan.data  = data;
      csr_chan.valid = 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic set_config(logic [CFG_W-1:0] req_bytes, logic [CFG_W-1:0] align,
                             logic [CFG_W-1:0] per_packet);
      drain();
      write_reg(REG_REQ_SIZE, req_bytes);
      write_reg(REG_ALIGN, align);
      write_reg(REG_RPP, per_packet);
   endtask

   // Mostly consecutive CSR rows ending in a graph close, with some noise and reversed rows.
   task automatic random_graph(int count);
      int                     pick;
      logic [OFFSET_BITS-1:0] first, next, degree;
      logic                   act, part_close, graph_close;
      row_cursor = OFFSET_BITS'({$urandom, $urandom});
      if ($urandom_range(0, 1) == 0)
         row_cursor = row_cursor & ~OFFSET_BITS'(16'hFFFF);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         act         = ($urandom_range(0, 3) != 0);
         part_close  = ($urandom_range(0, 4) == 0);
         graph_close = (i == count - 1);
         if (pick == 0) begin
            first       = OFFSET_BITS'({$urandom, $urandom});
            next        = OFFSET_BITS'({$urandom, $urandom});
            part_close  = 1'($urandom_range(0, 1));
            graph_close = graph_close | ($urandom_range(0, 7) == 0);
         end else if (pick == 1) begin
            first = row_cursor + OFFSET_BITS'($urandom_range(1, 5000));
            next  = row_cursor;
         end else begin
            degree     = (pick == 2) ? OFFSET_BITS'($urandom_range(0, 1 << 20))
                                     : OFFSET_BITS'($urandom_range(0, 64));
            first      = row_cursor;
            next       = row_cursor + degree;
            row_cursor = next;
         end
         send_vertex(first, next, act, part_close, graph_close);
      end
   endtask

   initial begin
      reset                     = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.row_start        = '0;
      req_chan.row_stop         = '0;
      req_chan.active           = 1'b0;
      req_chan.closes_partition = 1'b0;
      req_chan.closes_graph     = 1'b0;
      csr_chan.valid            = 1'b0;
      csr_chan.index            = REG_REQ_SIZE;
      csr_chan.data             = '0;
      row_cursor                = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_vertex(0, 0, 1'b1, 1'b0, 1'b0);
      send_vertex(1, 17, 1'b1, 1'b0, 1'b0);
      send_vertex(5, 900, 1'b0, 1'b0, 1'b0);
      send_vertex(100, 5, 1'b1, 1'b0, 1'b0);
      send_vertex(16, 48, 1'b1, 1'b1, 1'b0);
      send_vertex(0, 3, 1'b0, 1'b1, 1'b0);
      send_vertex(0, OFS_MAX, 1'b1, 1'b0, 1'b0);
      send_vertex(OFS_MAX, OFS_MAX, 1'b1, 1'b0, 1'b0);
      send_vertex(0, OFS_MAX, 1'b1, 1'b0, 1'b0);
      send_vertex(3, 3, 1'b0, 1'b0, 1'b1);
      send_vertex(33, 40, 1'b1, 1'b1, 1'b1);
      send_vertex(12, 11, 1'b0, 1'b0, 1'b1);
      send_vertex(64, 1064, 1'b1, 1'b0, 1'b1);

      // With one-byte requests two full-range rows saturate the request sums.
      set_config(13'd1, 13'd1, 13'd0);
      send_vertex(0, OFS_MAX, 1'b1, 1'b0, 1'b0);
      send_vertex(1, OFS_MAX, 1'b1, 1'b0, 1'b0);
      send_vertex(2, 1001, 1'b1, 1'b1, 1'b1);
      random_graph(24);

      set_config(13'd0, 13'd0, 13'd1024);
      random_graph(24);

      set_config(13'd4096, 13'd4096, 13'h1FFF);
      write_reg(REG_SPARE, 13'h1555);
      random_graph(24);

      set_config(13'h1FFF, 13'd3, 13'd7);
      random_graph(24);

      set_config(13'd37, 13'd24, 13'd5);
      random_graph(24);

      set_config(13'd128, 13'd64, 13'd1);
      random_graph(24);

      drain();
      if (mismatch_count == 0 && records_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== zero_copy_request_estimator.f =====
+incdir+hdl
hdl/zcre_pkg.sv
hdl/zcre_ifs.sv
hdl/zcre_div.sv
hdl/zcre_acc.sv
hdl/zero_copy_request_estimator.sv
dv/zcre_estimate_checker.sv
dv/zero_copy_request_estimator_tb.sv
